### rtl/pwlps_pkg.sv
// Shared types and constants of the piecewise linear density sampler.
// No dependencies; used by pwlps_div, the top level and the checker.
package pwlps_pkg;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_REJECT  = 2'd1;
    localparam logic [1:0] ST_REFUSED = 2'd2;

    localparam logic REG_FLAT_LIMIT = 1'b0;

    localparam int DIV_NW = 81;
    localparam int DIV_DW = 34;
    localparam int DIV_QW = 41;

    localparam logic [5:0] DIV_QB_NARROW = 6'd32;
    localparam logic [5:0] DIV_QB_WIDE   = 6'd41;

    typedef struct packed {
        logic                start;
        logic [DIV_NW-1:0]   dividend;
        logic [DIV_DW-1:0]   divisor;
        logic [5:0]          qbits;
        logic [DIV_QW-1:0]   cap;
    } div_req_t;

    typedef struct packed {
        logic                done;
        logic [DIV_QW-1:0]   quot;
    } div_rsp_t;

endpackage

### rtl/pwlps_div.sv
// Restoring divider, one quotient bit per cycle: min(floor(dividend/divisor), cap).
// Depends on pwlps_pkg (request and response structs).
module pwlps_div (
    input  logic                clk,
    input  logic                rst_n,
    input  pwlps_pkg::div_req_t req,
    output pwlps_pkg::div_rsp_t rsp
);

    logic                          run_reg;
    logic                          done_reg;
    logic [5:0]                    cnt_reg;
    logic [pwlps_pkg::DIV_DW-1:0]  rem_reg;
    logic [pwlps_pkg::DIV_DW-1:0]  den_reg;
    logic [pwlps_pkg::DIV_QW-1:0]  lo_reg;
    logic [pwlps_pkg::DIV_QW-1:0]  q_reg;
    logic [pwlps_pkg::DIV_QW-1:0]  cap_reg;
    logic [pwlps_pkg::DIV_NW-1:0]  hi;
    logic                          sat;
    logic [pwlps_pkg::DIV_DW:0]    trial;
    logic [pwlps_pkg::DIV_DW:0]    diff;
    logic                          ge;

    // quotient would not fit in qbits bits: it is above any cap
    assign hi    = req.dividend >> req.qbits;
    assign sat   = hi >= {{(pwlps_pkg::DIV_NW-pwlps_pkg::DIV_DW){1'b0}}, req.divisor};
    assign trial = {rem_reg, lo_reg[pwlps_pkg::DIV_QW-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign ge    = trial >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                run_reg  <= !sat;
                done_reg <= sat;
                cnt_reg  <= req.qbits;
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 6'd1;
                if (cnt_reg == 6'd1)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            den_reg <= req.divisor;
            cap_reg <= req.cap;
            rem_reg <= hi[pwlps_pkg::DIV_DW-1:0];
            lo_reg  <= req.dividend[pwlps_pkg::DIV_QW-1:0] << (6'd41 - req.qbits);
            q_reg   <= sat ? req.cap : '0;
        end
        else if (run_reg)
        begin
            rem_reg <= ge ? diff[pwlps_pkg::DIV_DW-1:0] : trial[pwlps_pkg::DIV_DW-1:0];
            q_reg   <= {q_reg[pwlps_pkg::DIV_QW-2:0], ge};
            lo_reg  <= {lo_reg[pwlps_pkg::DIV_QW-2:0], 1'b0};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = (q_reg > cap_reg) ? cap_reg : q_reg;

endmodule

### rtl/pwlps_sqrt.sv
// Integer square root of a 64-bit value, two radicand bits per cycle.
// No dependencies.
module pwlps_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0] v_reg;
    logic [63:0] res_reg;
    logic [4:0]  i_reg;
    logic        run_reg;
    logic        done_reg;
    logic [63:0] bitv;
    logic [63:0] sum;
    logic        take;

    assign bitv = 64'd1 << {i_reg, 1'b0};
    assign sum  = res_reg + bitv;
    assign take = v_reg >= sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                i_reg   <= 5'd31;
            end
            else if (run_reg)
            begin
                i_reg <= i_reg - 5'd1;
                if (i_reg == 5'd0)
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            v_reg   <= radicand;
            res_reg <= '0;
        end
        else if (run_reg)
        begin
            if (take)
            begin
                v_reg   <= v_reg - sum;
                res_reg <= (res_reg >> 1) + bitv;
            end
            else
            begin
                res_reg <= res_reg >> 1;
            end
        end
    end

    assign done = done_reg;
    assign root = res_reg[31:0];

endmodule

### rtl/piecewise_linear_pdf_sampler.sv
// Piecewise linear density sampler: point table in one memory, sequencer, math units.
// Depends on pwlps_pkg, pwlps_div and pwlps_sqrt.
//
//  channel   signals                                           handshake
//  request   operation new_table point_x point_pdf uniform_draw start & !busy
//  result    status sample_value min_value max_value mean_height done, 1 cycle
//  config    psel penable pwrite paddr pwdata prdata pready    APB, pready tied high
//
// A load's time is set by the mean-height division; a sample's time is set by the
// 1-bit-per-cycle divider (up to three passes per item), the square root and one
// table memory read per search step, so it grows with n (1 .. MAX_POINTS-1), the
// interval found by the search.
// Reset clears the point count and sets the slope limit to 1; no memory clearing is needed.
// busy stays high from acceptance through the done cycle; results cannot be stalled.
module piecewise_linear_pdf_sampler #(
    parameter int MAX_POINTS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               start,
    output logic               busy,
    input  logic               operation,
    input  logic               new_table,
    input  logic signed [31:0] point_x,
    input  logic [31:0]        point_pdf,
    input  logic [31:0]        uniform_draw,
    output logic               done,
    output logic [1:0]         status,
    output logic signed [31:0] sample_value,
    output logic signed [31:0] min_value,
    output logic signed [31:0] max_value,
    output logic [31:0]        mean_height
);

    localparam int AW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [25:0] {
        S_IDLE  = 26'd1 << 0,
        S_LDMUL = 26'd1 << 1,
        S_LDWR  = 26'd1 << 2,
        S_TGT1  = 26'd1 << 3,
        S_TGT2  = 26'd1 << 4,
        S_TGT3  = 26'd1 << 5,
        S_SRD   = 26'd1 << 6,
        S_SCMP  = 26'd1 << 7,
        S_SRD0  = 26'd1 << 8,
        S_SGOT0 = 26'd1 << 9,
        S_PREP  = 26'd1 << 10,
        S_KCHK  = 26'd1 << 11,
        S_KSEL  = 26'd1 << 12,
        S_HDIV  = 26'd1 << 13,
        S_DSQ   = 26'd1 << 14,
        S_TLO   = 26'd1 << 15,
        S_THI   = 26'd1 << 16,
        S_TCMB  = 26'd1 << 17,
        S_DCMB  = 26'd1 << 18,
        S_SQW   = 26'd1 << 19,
        S_DSEL  = 26'd1 << 20,
        S_FDIV  = 26'd1 << 21,
        S_FIN   = 26'd1 << 22,
        S_MCHK  = 26'd1 << 23,
        S_MDIV  = 26'd1 << 24,
        S_EMIT  = 26'd1 << 25
    } state_t;

    state_t state_reg, state_next;

    logic [CW-1:0]        count_reg, count_next;
    logic [15:0]          limit_reg;

    // table memory: {x, pdf, cumulative area}
    logic [127:0]         mem [MAX_POINTS];
    logic [127:0]         mem_q;
    logic [AW-1:0]        mem_raddr;
    logic                 mem_we;
    logic [63:0]          cum_new;

    logic signed [31:0]   px_reg, first_x_reg, last_x_reg, x0_reg, x1_reg, sample_reg;
    logic [31:0]          pp_reg, last_p_reg, u_reg, p0_reg, p1_reg, dx_reg, dp_reg;
    logic [31:0]          t_reg, mean_reg;
    logic [32:0]          s_reg, denom_reg;
    logic [48:0]          area_reg, r_reg;
    logic [63:0]          total_reg, m1_reg, m2_reg, target_reg, c0_reg, c1_reg;
    logic [63:0]          d0_reg, tl_reg, term_reg, d_comb;
    logic [40:0]          th_reg, h_reg;
    logic [1:0]           status_reg;
    logic [AW-1:0]        n_reg;
    logic                 flat_reg, up_reg;

    logic [CW-1:0]        cnt_eff;
    logic                 reject;
    logic                 more;
    logic [64:0]          trap_prod;
    logic [63:0]          c_diff, r_full;
    logic [48:0]          lim_prod;
    logic [72:0]          term_sum;
    logic [31:0]          span;

    pwlps_pkg::div_req_t  div_req;
    pwlps_pkg::div_rsp_t  div_rsp;
    logic                 sq_start, sq_done;
    logic [31:0]          sq_root;

    pwlps_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pwlps_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (d_comb),
        .done     (sq_done),
        .root     (sq_root)
    );

    assign cnt_eff = (operation == pwlps_pkg::OP_LOAD && new_table) ? '0 : count_reg;
    assign reject  = (cnt_eff == CW'(MAX_POINTS)) ||
                     ((cnt_eff != '0) && (point_x <= last_x_reg));
    assign more    = (CW'(n_reg) < (count_reg - CW'(1))) && (mem_q[63:0] <= target_reg);
    assign trap_prod = {33'b0, dx_reg} * {32'b0, s_reg};
    assign cum_new = (count_reg == '0) ? 64'd0 : total_reg + {15'b0, area_reg};
    assign c_diff  = c1_reg - c0_reg;
    assign r_full  = target_reg - c0_reg;
    assign lim_prod = ({1'b0, limit_reg} + 17'd1) * {17'b0, dx_reg};
    assign term_sum = {th_reg, 32'b0} + {9'b0, tl_reg};
    assign span    = last_x_reg - first_x_reg;
    assign mem_we  = (state_reg == S_LDWR);

    always_comb
    begin
        if (up_reg)
            d_comb = (term_reg > ~d0_reg) ? '1 : d0_reg + term_reg;
        else
            d_comb = (term_reg > d0_reg) ? '0 : d0_reg - term_reg;
    end

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        div_req    = '0;
        sq_start   = 1'b0;
        mem_raddr  = n_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == pwlps_pkg::OP_LOAD)
                    begin
                        count_next = cnt_eff;
                        state_next = reject ? S_MCHK : S_LDMUL;
                    end
                    else
                    begin
                        state_next = (count_reg < CW'(2)) ? S_MCHK : S_TGT1;
                    end
                end
            end
            S_LDMUL: state_next = S_LDWR;
            S_LDWR:
            begin
                count_next = count_reg + CW'(1);
                state_next = S_MCHK;
            end
            S_TGT1:  state_next = S_TGT2;
            S_TGT2:  state_next = S_TGT3;
            S_TGT3:  state_next = S_SRD;
            S_SRD:   state_next = S_SCMP;
            S_SCMP:  state_next = more ? S_SRD : S_SRD0;
            S_SRD0:
            begin
                mem_raddr  = n_reg - AW'(1);
                state_next = S_SGOT0;
            end
            S_SGOT0: state_next = S_PREP;
            S_PREP:  state_next = S_KCHK;
            S_KCHK:  state_next = S_KSEL;
            S_KSEL:
            begin
                if (flat_reg)
                begin
                    if (p0_reg == '0)
                        state_next = S_FIN;
                    else
                    begin
                        div_req.start    = 1'b1;
                        div_req.dividend = {16'b0, r_reg, 16'b0};
                        div_req.divisor  = {2'b0, p0_reg};
                        div_req.qbits    = pwlps_pkg::DIV_QB_NARROW;
                        div_req.cap      = {9'b0, dx_reg};
                        state_next       = S_FDIV;
                    end
                end
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {15'b0, r_reg, 17'b0};
                    div_req.divisor  = {2'b0, dx_reg};
                    div_req.qbits    = pwlps_pkg::DIV_QB_WIDE;
                    div_req.cap      = 41'd1 << 40;
                    state_next       = S_HDIV;
                end
            end
            S_HDIV:  state_next = div_rsp.done ? S_DSQ : S_HDIV;
            S_DSQ:   state_next = S_TLO;
            S_TLO:   state_next = S_THI;
            S_THI:   state_next = S_TCMB;
            S_TCMB:  state_next = S_DCMB;
            S_DCMB:
            begin
                sq_start   = 1'b1;
                state_next = S_SQW;
            end
            S_SQW:   state_next = sq_done ? S_DSEL : S_SQW;
            S_DSEL:
            begin
                if (denom_reg == '0)
                    state_next = S_FIN;
                else
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {15'b0, r_reg, 17'b0};
                    div_req.divisor  = {1'b0, denom_reg};
                    div_req.qbits    = pwlps_pkg::DIV_QB_NARROW;
                    div_req.cap      = {9'b0, dx_reg};
                    state_next       = S_FDIV;
                end
            end
            S_FDIV:  state_next = div_rsp.done ? S_FIN : S_FDIV;
            S_FIN:   state_next = S_MCHK;
            S_MCHK:
            begin
                if (count_reg >= CW'(2))
                begin
                    div_req.start    = 1'b1;
                    div_req.dividend = {1'b0, total_reg, 16'b0};
                    div_req.divisor  = {2'b0, span};
                    div_req.qbits    = pwlps_pkg::DIV_QB_NARROW;
                    div_req.cap      = 41'h0_FFFF_FFFF;
                    state_next       = S_MDIV;
                end
                else
                    state_next = S_EMIT;
            end
            S_MDIV:  state_next = div_rsp.done ? S_EMIT : S_MDIV;
            S_EMIT:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
            limit_reg <= 16'd1;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (psel && penable && pwrite && paddr[2] == pwlps_pkg::REG_FLAT_LIMIT)
                limit_reg <= pwdata[15:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[count_reg[AW-1:0]] <= {px_reg, pp_reg, cum_new};
        mem_q <= mem[mem_raddr];
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    px_reg     <= point_x;
                    pp_reg     <= point_pdf;
                    u_reg      <= uniform_draw;
                    sample_reg <= '0;
                    dx_reg     <= point_x - last_x_reg;
                    s_reg      <= {1'b0, last_p_reg} + {1'b0, point_pdf};
                    if (operation == pwlps_pkg::OP_LOAD)
                        status_reg <= reject ? pwlps_pkg::ST_REJECT : pwlps_pkg::ST_OK;
                    else
                        status_reg <= (count_reg < CW'(2)) ? pwlps_pkg::ST_REFUSED
                                                            : pwlps_pkg::ST_OK;
                end
            end
            S_LDMUL:
            begin
                // trapezoid area = floor(dx * (p0 + p1) / 2^17)
                area_reg <= (count_reg == '0) ? '0 : {1'b0, trap_prod[64:17]};
            end
            S_LDWR:
            begin
                total_reg  <= cum_new;
                last_x_reg <= px_reg;
                last_p_reg <= pp_reg;
                if (count_reg == '0)
                    first_x_reg <= px_reg;
            end
            S_TGT1: m1_reg <= {32'b0, u_reg} * {32'b0, total_reg[63:32]};
            S_TGT2: m2_reg <= {32'b0, u_reg} * {32'b0, total_reg[31:0]};
            S_TGT3:
            begin
                target_reg <= m1_reg + {32'b0, m2_reg[63:32]};
                n_reg      <= AW'(1);
            end
            S_SCMP:
            begin
                if (more)
                    n_reg <= n_reg + AW'(1);
                else
                begin
                    x1_reg <= mem_q[127:96];
                    p1_reg <= mem_q[95:64];
                    c1_reg <= mem_q[63:0];
                end
            end
            S_SGOT0:
            begin
                x0_reg <= mem_q[127:96];
                p0_reg <= mem_q[95:64];
                c0_reg <= mem_q[63:0];
            end
            S_PREP:
            begin
                dx_reg   <= x1_reg - x0_reg;
                area_reg <= c_diff[48:0];
                r_reg    <= (r_full > c_diff) ? c_diff[48:0] : r_full[48:0];
                dp_reg   <= (p1_reg >= p0_reg) ? p1_reg - p0_reg : p0_reg - p1_reg;
                up_reg   <= p1_reg >= p0_reg;
            end
            // |k| <= limit  <=>  dp * 2^16 < (limit + 1) * dx
            S_KCHK: flat_reg <= {1'b0, dp_reg, 16'b0} < lim_prod;
            S_KSEL:
            begin
                if (flat_reg && p0_reg == '0)
                    t_reg <= (r_reg == '0) ? '0 : dx_reg;
            end
            S_HDIV:
            begin
                if (div_rsp.done)
                    h_reg <= div_rsp.quot;
            end
            S_DSQ: d0_reg <= {32'b0, p0_reg} * {32'b0, p0_reg};
            S_TLO: tl_reg <= {32'b0, dp_reg} * {32'b0, h_reg[31:0]};
            S_THI: th_reg <= {9'b0, dp_reg} * {32'b0, h_reg[40:32]};
            S_TCMB: term_reg <= (term_sum[72:64] != '0) ? '1 : term_sum[63:0];
            S_SQW:
            begin
                if (sq_done)
                    denom_reg <= {1'b0, p0_reg} + {1'b0, sq_root};
            end
            S_DSEL:
            begin
                if (denom_reg == '0)
                    t_reg <= '0;
            end
            S_FDIV:
            begin
                if (div_rsp.done)
                    t_reg <= div_rsp.quot[31:0];
            end
            S_FIN: sample_reg <= x0_reg + t_reg;
            S_MCHK:
            begin
                if (count_reg < CW'(2))
                    mean_reg <= '0;
            end
            S_MDIV:
            begin
                if (div_rsp.done)
                    mean_reg <= div_rsp.quot[31:0];
            end
            default:
            begin
            end
        endcase
    end

    assign pready       = 1'b1;
    assign prdata       = (paddr[2] == pwlps_pkg::REG_FLAT_LIMIT) ? {16'b0, limit_reg} : '0;
    assign busy         = (state_reg != S_IDLE);
    assign done         = (state_reg == S_EMIT);
    assign status       = status_reg;
    assign sample_value = sample_reg;
    assign min_value    = (count_reg != '0) ? first_x_reg : '0;
    assign max_value    = (count_reg != '0) ? last_x_reg : '0;
    assign mean_height  = mean_reg;

endmodule

### rtl/pwlps_checker.sv
// Port-level checks of the sampler's request/result sequencing and of failed-result samples, bound to the top level.
// Depends on pwlps_pkg and piecewise_linear_pdf_sampler.
module pwlps_checker (
    input logic               clk,
    input logic               rst_n,
    input logic               start,
    input logic               busy,
    input logic               done,
    input logic [1:0]         status,
    input logic signed [31:0] sample_value
);

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("result outside a busy window");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done)
        else $error("result strobe longer than one cycle");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == pwlps_pkg::ST_REJECT || status == pwlps_pkg::ST_REFUSED))
        |-> (sample_value == 32'sd0))
        else $error("failed request carries a sample");

    a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> $past(done))
        else $error("busy dropped without a result");

endmodule

bind piecewise_linear_pdf_sampler pwlps_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .done         (done),
    .status       (status),
    .sample_value (sample_value)
);

### test/piecewise_linear_pdf_sampler_tb.sv
// Testbench for piecewise_linear_pdf_sampler: directed and random load/sample requests,
// checked against an in-bench bit-exact predictor. Depends on pwlps_pkg and the RTL top.
`timescale 1ns / 100ps

module piecewise_linear_pdf_sampler_tb;

    localparam int TABLE_DEPTH = 64;
    localparam int STALL_LIMIT = 5000;
    localparam int RANDOM_REQUESTS = 1150;

    typedef struct {
        logic [1:0]  status;
        logic [31:0] sample_value;
        logic [31:0] min_value;
        logic [31:0] max_value;
        logic [31:0] mean_height;
    } sampler_result_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        start;
    logic        busy;
    logic        operation;
    logic        new_table;
    logic signed [31:0] point_x;
    logic [31:0] point_pdf;
    logic [31:0] uniform_draw;
    logic        done;
    logic [1:0]  status;
    logic signed [31:0] sample_value;
    logic signed [31:0] min_value;
    logic signed [31:0] max_value;
    logic [31:0] mean_height;

    // predictor state
    longint      knot_x [TABLE_DEPTH];
    logic [63:0] knot_pdf [TABLE_DEPTH];
    logic [63:0] cum_area [TABLE_DEPTH];
    int          knot_count;
    logic [63:0] flat_limit;

    sampler_result_t pending_results[$];
    int          error_count;
    int          stall_cycles;
    int          request_count;

    piecewise_linear_pdf_sampler u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .new_table    (new_table),
        .point_x      (point_x),
        .point_pdf    (point_pdf),
        .uniform_draw (uniform_draw),
        .done         (done),
        .status       (status),
        .sample_value (sample_value),
        .min_value    (min_value),
        .max_value    (max_value),
        .mean_height  (mean_height)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // floor(num * 2^sh / den), saturating at cap
    function automatic logic [63:0] scaled_quotient(input logic [63:0] num, input int sh,
                                                    input logic [63:0] den,
                                                    input logic [63:0] cap);
        logic [127:0] q;
        q = ({64'd0, num} << sh) / {64'd0, den};
        return (q > {64'd0, cap}) ? cap : q[63:0];
    endfunction

    function automatic logic [63:0] int_sqrt(input logic [63:0] v);
        logic [63:0] res;
        logic [63:0] b;
        res = 64'd0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v = v - (res + b);
                res = (res >> 1) + b;
            end
            else
                res = res >> 1;
            b = b >> 2;
        end
        return res;
    endfunction

    function automatic logic [63:0] interval_area(input logic [63:0] dx, input logic [63:0] p0,
                                                  input logic [63:0] p1);
        logic [127:0] prod;
        prod = {64'd0, dx} * ({64'd0, p0} + {64'd0, p1});
        return prod[80:17];
    endfunction

    // offset of the sample inside interval n for the given area target
    function automatic logic [63:0] interval_offset(input int n, input logic [63:0] target);
        logic [63:0] dx, p0, p1, area, r, dp, slope_mag, h, d, term, denom;
        logic [127:0] wide_term;
        dx = knot_x[n] - knot_x[n-1];
        p0 = knot_pdf[n-1];
        p1 = knot_pdf[n];
        area = cum_area[n] - cum_area[n-1];
        r = target - cum_area[n-1];
        dp = (p1 >= p0) ? p1 - p0 : p0 - p1;
        if (r > area) r = area;
        slope_mag = (dp << 16) / dx;
        if (slope_mag <= flat_limit)
        begin
            if (p0 == 0) return (r == 0) ? 64'd0 : dx;
            return scaled_quotient(r, 16, p0, dx);
        end
        h = scaled_quotient(r, 17, dx, 64'd1 << 40);
        d = p0 * p0;
        wide_term = {64'd0, dp} * {64'd0, h};
        term = (wide_term[127:64] != 0) ? '1 : wide_term[63:0];
        if (p1 >= p0)
            d = (term > ~d) ? '1 : d + term;
        else
            d = (term > d) ? 64'd0 : d - term;
        denom = p0 + int_sqrt(d);
        if (denom == 0) return 64'd0;
        return scaled_quotient(r, 17, denom, dx);
    endfunction

    function automatic sampler_result_t predict_request(input logic op, input logic nt,
                                                        input logic signed [31:0] px,
                                                        input logic [31:0] pp,
                                                        input logic [31:0] u);
        sampler_result_t res;
        logic [63:0] total, target, span;
        logic [127:0] wide;
        longint x;
        int n;
        res = '{pwlps_pkg::ST_OK, 32'd0, 32'd0, 32'd0, 32'd0};
        if (op == pwlps_pkg::OP_LOAD)
        begin
            if (nt) knot_count = 0;
            if (knot_count >= TABLE_DEPTH ||
                (knot_count > 0 && longint'(px) <= knot_x[knot_count-1]))
                res.status = pwlps_pkg::ST_REJECT;
            else
            begin
                knot_x[knot_count] = px;
                knot_pdf[knot_count] = {32'd0, pp};
                if (knot_count == 0)
                    cum_area[0] = 64'd0;
                else
                    cum_area[knot_count] = cum_area[knot_count-1] +
                        interval_area(longint'(px) - knot_x[knot_count-1],
                                      knot_pdf[knot_count-1], {32'd0, pp});
                knot_count++;
            end
        end
        else if (knot_count < 2)
            res.status = pwlps_pkg::ST_REFUSED;
        else
        begin
            total = cum_area[knot_count-1];
            wide = {96'd0, u} * {64'd0, total};
            target = wide[95:32];
            n = 1;
            while (n < knot_count - 1 && cum_area[n] <= target) n++;
            x = knot_x[n-1] + longint'(interval_offset(n, target));
            res.sample_value = x[31:0];
        end
        if (knot_count > 0)
        begin
            res.min_value = knot_x[0][31:0];
            res.max_value = knot_x[knot_count-1][31:0];
        end
        if (knot_count >= 2)
        begin
            span = knot_x[knot_count-1] - knot_x[0];
            res.mean_height = scaled_quotient(cum_area[knot_count-1], 16, span,
                                              64'hFFFF_FFFF);
        end
        return res;
    endfunction

    // result checker
    always @(posedge clk)
    begin
        sampler_result_t exp_r;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request outstanding");
                error_count++;
            end
            else
            begin
                exp_r = pending_results.pop_front();
                if (status !== exp_r.status)
                begin
                    $error("status: expected %0d actual %0d", exp_r.status, status);
                    error_count++;
                end
                if (sample_value !== exp_r.sample_value)
                begin
                    $error("sample_value: expected %h actual %h", exp_r.sample_value,
                           sample_value);
                    error_count++;
                end
                if (min_value !== exp_r.min_value)
                begin
                    $error("min_value: expected %h actual %h", exp_r.min_value, min_value);
                    error_count++;
                end
                if (max_value !== exp_r.max_value)
                begin
                    $error("max_value: expected %h actual %h", exp_r.max_value, max_value);
                    error_count++;
                end
                if (mean_height !== exp_r.mean_height)
                begin
                    $error("mean_height: expected %h actual %h", exp_r.mean_height,
                           mean_height);
                    error_count++;
                end
            end
        end
    end

    // watchdog: cycles with no request taken and no result
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || done)
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    function automatic int random_gap();
        if ($urandom_range(0, 15) == 0) return $urandom_range(5, 40);
        if ($urandom_range(0, 3) == 0) return 0;
        return $urandom_range(0, 3);
    endfunction

    // start is left high after acceptance; busy keeps a second request from being taken
    task automatic send_request(input logic op, input logic nt, input logic [31:0] px,
                                input logic [31:0] pp, input logic [31:0] u);
        int gap;
        gap = random_gap();
        if (gap > 0)
        begin
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        start <= 1'b1;
        operation <= op;
        new_table <= nt;
        point_x <= px;
        point_pdf <= pp;
        uniform_draw <= u;
        do @(posedge clk); while (busy);
        pending_results.push_back(predict_request(op, nt, px, pp, u));
        request_count++;
    endtask

    task automatic drain_requests();
        @(negedge clk);
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_flat_limit(input logic [15:0] value);
        drain_requests();
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {pwlps_pkg::REG_FLAT_LIMIT, 2'b00};
        pwdata <= {16'd0, value};
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        flat_limit = {48'd0, value};
    endtask

    task automatic test_refusals();
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'h8000_0000);
        send_request(pwlps_pkg::OP_LOAD, 1'b1, 32'h0001_0000, 32'h0002_0000, 32'd0);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b1, 32'd0, 32'd0, 32'h1234_5678);
    endtask

    task automatic test_rejections();
        send_request(pwlps_pkg::OP_LOAD, 1'b0, 32'h0001_0000, 32'h0001_0000, 32'd0);
        send_request(pwlps_pkg::OP_LOAD, 1'b0, 32'h0000_8000, 32'h0001_0000, 32'd0);
        send_request(pwlps_pkg::OP_LOAD, 1'b0, 32'h0003_0000, 32'h0000_0000, 32'd0);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'hC000_0000);
    endtask

    task automatic test_extremes();
        send_request(pwlps_pkg::OP_LOAD, 1'b1, 32'h8000_0000, 32'hFFFF_FFFF, 32'd0);
        send_request(pwlps_pkg::OP_LOAD, 1'b0, 32'h7FFF_FFFF, 32'h0000_0000, 32'd0);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'h0000_0000);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'hFFFF_FFFF);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'h5555_5555);
    endtask

    task automatic test_empty_density();
        send_request(pwlps_pkg::OP_LOAD, 1'b1, 32'hFFFF_0000, 32'd0, 32'd0);
        send_request(pwlps_pkg::OP_LOAD, 1'b0, 32'h0002_0000, 32'd0, 32'd0);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'hAAAA_AAAA);
    endtask

    // same sloped table solved by quadratic, then by linear, then again by quadratic form
    task automatic test_flat_and_sloped();
        send_request(pwlps_pkg::OP_LOAD, 1'b1, 32'd0, 32'h0000_0000, 32'd0);
        send_request(pwlps_pkg::OP_LOAD, 1'b0, 32'h0004_0000, 32'h0000_0100, 32'd0);
        send_request(pwlps_pkg::OP_LOAD, 1'b0, 32'h0008_0000, 32'h0000_0080, 32'd0);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'h3000_0000);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'hE000_0000);
        write_flat_limit(16'hFFFF);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'h3000_0000);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'hE000_0000);
        write_flat_limit(16'h0000);
        send_request(pwlps_pkg::OP_SAMPLE, 1'b0, 32'd0, 32'd0, 32'h3000_0000);
    endtask

    function automatic logic [31:0] random_density();
        if ($urandom_range(0, 9) == 0) return 32'd0;
        return $urandom >> $urandom_range(0, 31);
    endfunction

    task automatic test_random_tables();
        int points, draws, i;
        longint x;
        logic [15:0] lim;
        while (request_count < RANDOM_REQUESTS)
        begin
            if ($urandom_range(0, 9) == 0)
            begin
                case ($urandom_range(0, 3))
                    0: lim = 16'h0000;
                    1: lim = 16'hFFFF;
                    default: lim = 16'($urandom >> $urandom_range(0, 16));
                endcase
                write_flat_limit(lim);
            end
            if ($urandom_range(0, 29) == 0)
                points = TABLE_DEPTH;
            else
                points = $urandom_range(2, 8);
            x = longint'($signed($urandom)) >>> $urandom_range(0, 12);
            send_request(pwlps_pkg::OP_LOAD, 1'b1, x[31:0], random_density(), $urandom);
            for (i = 1; i < points; i++)
            begin
                x = x + $urandom_range(1, 1 << $urandom_range(0, 24));
                if (x > 64'sh7FFF_FFFF) break;
                send_request(pwlps_pkg::OP_LOAD, 1'b0, x[31:0], random_density(), $urandom);
            end
            if (points == TABLE_DEPTH)
                send_request(pwlps_pkg::OP_LOAD, 1'b0, 32'h7FFF_FFFF, $urandom, $urandom);
            draws = $urandom_range(1, 10);
            for (i = 0; i < draws; i++)
            begin
                if ($urandom_range(0, 9) == 0)
                    send_request(1'($urandom_range(0, 1)),
                                 1'($urandom_range(0, 1) & $urandom),
                                 $urandom, $urandom, $urandom);
                else
                    send_request(pwlps_pkg::OP_SAMPLE, 1'($urandom_range(0, 1)), $urandom,
                                 $urandom, $urandom);
            end
        end
    endtask

    initial
    begin
        error_count = 0;
        request_count = 0;
        knot_count = 0;
        flat_limit = 64'd1;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        start = 1'b0;
        operation = pwlps_pkg::OP_LOAD;
        new_table = 1'b0;
        point_x = '0;
        point_pdf = '0;
        uniform_draw = '0;
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_refusals();
        test_rejections();
        test_extremes();
        test_empty_density();
        test_flat_and_sloped();
        write_flat_limit(16'd1);
        request_count = 0;
        test_random_tables();

        drain_requests();
        repeat (400) @(posedge clk);
        if (error_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
